/* src/crdq_pkg.sv */
// Package for the circular deque ring: operation codes, constants and the
// status struct passed from the control unit to the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package crdq_pkg;

  localparam int FUNC_W    = 3;
  localparam int WORD_W    = 32;
  localparam int CAP_REG_W = 7;
  localparam int CAP_RESET = 64;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd4;

  // Word reported for front and rear while the deque is empty
  localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

  typedef struct packed {
    logic ok;
    logic empty;
    logic full;
  } crdq_stat_t;

endpackage

`default_nettype wire

/* src/crdq_ram.sv */
// Ring storage: one write port and two registered read ports, write-first.
// Depends on crdq_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module crdq_ram import crdq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic signed [WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr_a,
  input  wire logic [AW-1:0]            raddr_b,
  output logic signed [WORD_W-1:0]      rdata_a,
  output logic signed [WORD_W-1:0]      rdata_b
);

  logic signed [WORD_W-1:0] mem_r [0:DEPTH-1];
  logic signed [WORD_W-1:0] rd_a_r;
  logic signed [WORD_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Forward the word being written when a read hits the same entry
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a_r <= (we && (waddr == raddr_a)) ? wdata : mem_r[raddr_a];
      rd_b_r <= (we && (waddr == raddr_b)) ? wdata : mem_r[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

`default_nettype wire

/* src/crdq_ctrl.sv */
// Deque control: head, count and capacity registers, operation decode and
// ring address arithmetic. Depends on crdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crdq_ctrl import crdq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic                 cfg_we,
  input  wire logic [CAP_REG_W-1:0] cfg_cap,
  output logic                      we,
  output logic [AW-1:0]             waddr,
  output logic [AW-1:0]             raddr_front,
  output logic [AW-1:0]             raddr_rear,
  output crdq_stat_t                stat
);

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int SW       = CW + 1;
  localparam int XW       = (CW > CAP_REG_W) ? CW : CAP_REG_W;
  localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;

  logic [SW-1:0] cap_s, head_s, cnt_s;
  logic [SW-1:0] head_nxt, count_nxt, wa_s, rear_s;
  logic          we_c, ok_c;
  logic [XW-1:0] cap_x;

  function automatic logic [SW-1:0] wrap(input logic [SW-1:0] s, input logic [SW-1:0] c);
    logic [SW-1:0] r;
    r = (s >= c) ? (s - c) : s;
    return r;
  endfunction

  // Saturate the written capacity into 1..DEPTH
  always_comb begin
    cap_x = XW'(cfg_cap);
    if (cap_x == '0) begin
      cap_nxt = CW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_nxt = CW'(DEPTH);
    end else begin
      cap_nxt = cap_x[CW-1:0];
    end
  end

  always_comb begin
    cap_s     = SW'(cap_r);
    head_s    = SW'(head_r);
    cnt_s     = SW'(count_r);
    head_nxt  = head_s;
    count_nxt = cnt_s;
    wa_s      = head_s;
    we_c      = 1'b0;
    ok_c      = 1'b0;
    case (func)
      FN_PUSH_FRONT: begin
        if (cnt_s < cap_s) begin
          head_nxt  = (head_s == '0) ? (cap_s - SW'(1)) : (head_s - SW'(1));
          wa_s      = head_nxt;
          count_nxt = cnt_s + SW'(1);
          we_c      = 1'b1;
          ok_c      = 1'b1;
        end
      end
      FN_PUSH_REAR: begin
        if (cnt_s < cap_s) begin
          wa_s      = wrap(head_s + cnt_s, cap_s);
          count_nxt = cnt_s + SW'(1);
          we_c      = 1'b1;
          ok_c      = 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (cnt_s != '0) begin
          head_nxt  = wrap(head_s + SW'(1), cap_s);
          count_nxt = cnt_s - SW'(1);
          ok_c      = 1'b1;
        end
      end
      FN_POP_REAR: begin
        if (cnt_s != '0) begin
          count_nxt = cnt_s - SW'(1);
          ok_c      = 1'b1;
        end
      end
      FN_QUERY: begin
        ok_c = 1'b1;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
    // Rear entry after the operation; meaningless when the deque ends empty
    rear_s = wrap(head_nxt + count_nxt - SW'(1), cap_s);
  end

  assign we          = acc & we_c;
  assign waddr       = wa_s[AW-1:0];
  assign raddr_front = head_nxt[AW-1:0];
  assign raddr_rear  = rear_s[AW-1:0];
  assign stat.ok     = ok_c;
  assign stat.empty  = (count_nxt == '0);
  assign stat.full   = (count_nxt == cap_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CW'(CAP_INIT);
      head_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      cap_r   <= cap_nxt;
      head_r  <= '0;
      count_r <= '0;
    end else if (acc) begin
      head_r  <= head_nxt[AW-1:0];
      count_r <= count_nxt[CW-1:0];
    end
  end

  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count exceeds capacity");

  a_head_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(head_r) < SW'(cap_r))
    else $error("head index outside ring");

endmodule

`default_nettype wire

/* src/circular_deque_ring_unit.sv */
// Circular deque ring unit: top level with the result register and handshakes.
// Depends on crdq_pkg, crdq_ctrl and crdq_ram.
// The result of an accepted transaction appears on out_* in the cycle after its acceptance.
// Throughput: one transaction per cycle while out_stall is low; the ring
//   memory takes one write and two reads per cycle, with write-first forwarding.
// Reset (synchronous, rst_n low): empty deque, head 0, capacity min(64, DEPTH);
//   ring contents are not cleared, only pushed entries are ever reported.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_ring_unit import crdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input transaction channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic signed [WORD_W-1:0] in_value,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_ok,
  output logic signed [WORD_W-1:0]      out_front_word,
  output logic signed [WORD_W-1:0]      out_rear_word,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  // capacity register write
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CAP_REG_W-1:0]     cfg_capacity
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     acc;
  logic                     cfg_we;
  logic                     ram_we;
  logic [AW-1:0]            waddr, raddr_front, raddr_rear;
  crdq_stat_t               stat;
  logic signed [WORD_W-1:0] rd_front, rd_rear;

  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_empty_r, out_full_r;

  // Take a new transaction whenever the result register is free or drains now
  assign in_stall  = out_valid_r & out_stall;
  assign acc       = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  crdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .func        (in_func),
    .cfg_we      (cfg_we),
    .cfg_cap     (cfg_capacity),
    .we          (ram_we),
    .waddr       (waddr),
    .raddr_front (raddr_front),
    .raddr_rear  (raddr_rear),
    .stat        (stat)
  );

  // Read the front and rear entries of the new state in the same cycle as the
  // write; the read registers double as the result payload, so load them only
  // on an accepted transaction to hold them steady while stalled.
  crdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .re      (acc),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (in_value),
    .raddr_a (raddr_front),
    .raddr_b (raddr_rear),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  // Result valid: set on accept, drop once taken, hold while stalled
  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Status payload, loaded with the transaction
  always_ff @(posedge clk) begin
    if (acc) begin
      out_ok_r    <= stat.ok;
      out_empty_r <= stat.empty;
      out_full_r  <= stat.full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;
  assign out_front_word = out_empty_r ? WORD_NONE : rd_front;
  assign out_rear_word  = out_empty_r ? WORD_NONE : rd_rear;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_empty_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && out_empty_r && out_full_r))
    else $error("deque reported empty and full at once");

  a_push_front_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && stat.ok && (in_func == FN_PUSH_FRONT)) |=>
      (out_front_word == $past(in_value)))
    else $error("pushed front word not reported at front");

  a_push_rear_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && stat.ok && (in_func == FN_PUSH_REAR)) |=>
      (out_rear_word == $past(in_value)))
    else $error("pushed rear word not reported at rear");

endmodule

`default_nettype wire
